// ----- design/tfc_pkg.sv -----
// Shared types, register codes and saturating arithmetic helpers for the
// torque feedforward to current command core. No dependencies.
package tfc_pkg;

  localparam int WORD_W       = 32;
  localparam int FRAC_BITS    = 16;
  localparam int INERTIA_FRAC = 32;
  localparam int CFG_W        = 31;
  localparam int ADDR_W       = 5;
  localparam int QBITS        = 31;
  localparam int PROD_W       = 64;
  localparam int MAG_W        = PROD_W - FRAC_BITS;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic        [WORD_W-1:0] uword_t;
  typedef logic        [CFG_W-1:0]  cfg_t;
  typedef logic        [2:0]        reg_idx_t;

  localparam reg_idx_t REG_ACCEL_GAIN       = 3'd0;
  localparam reg_idx_t REG_INERTIA          = 3'd1;
  localparam reg_idx_t REG_STATIC_FRICTION  = 3'd2;
  localparam reg_idx_t REG_VISCOUS_FRICTION = 3'd3;
  localparam reg_idx_t REG_TORQUE_LIMIT     = 3'd4;
  localparam reg_idx_t REG_CURRENT_LIMIT    = 3'd5;
  localparam reg_idx_t REG_TORQUE_CONSTANT  = 3'd6;

  localparam cfg_t ACCEL_GAIN_RESET = cfg_t'(65536);

  localparam word_t WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

  localparam logic [PROD_W-1:0] ROUND_INERTIA = PROD_W'(1) << (INERTIA_FRAC - 1);
  localparam logic [PROD_W-1:0] ROUND_FRAC    = PROD_W'(1) << (FRAC_BITS - 1);

  // Magnitude of a signed word; the most negative value maps to 2^(W-1).
  function automatic uword_t mag_word(input word_t v);
    mag_word = v[WORD_W-1] ? uword_t'(-v) : uword_t'(v);
  endfunction

  // Signed sum saturated to the word range.
  function automatic word_t sat_add(input word_t a, input word_t b);
    logic signed [WORD_W:0] s;
    s = {a[WORD_W-1], a} + {b[WORD_W-1], b};
    if (s[WORD_W] != s[WORD_W-1]) begin
      sat_add = s[WORD_W] ? WORD_MIN : WORD_MAX;
    end else begin
      sat_add = s[WORD_W-1:0];
    end
  endfunction

  // Applies a sign to a wide magnitude and saturates to the word range.
  function automatic word_t sat_mag(input logic neg, input logic [MAG_W-1:0] m);
    logic over_pos;
    logic over_neg;
    over_pos = |m[MAG_W-1:WORD_W-1];
    over_neg = (|m[MAG_W-1:WORD_W]) || (m[WORD_W-1] && (|m[WORD_W-2:0]));
    if (!neg) begin
      sat_mag = over_pos ? WORD_MAX : word_t'(m[WORD_W-1:0]);
    end else begin
      sat_mag = over_neg ? WORD_MIN : word_t'(uword_t'(0) - m[WORD_W-1:0]);
    end
  endfunction

endpackage

// ----- design/tfc_demand_if.sv -----
// Request channel carrying one torque demand per handshake.
// Depends on tfc_pkg.
interface tfc_demand_if import tfc_pkg::*; ();
  logic  valid;
  logic  ready;
  word_t feedback_torque;
  word_t accel_request;
  word_t velocity;
  logic  enable_in;

  modport source (output valid, feedback_torque, accel_request, velocity, enable_in,
                  input ready);
  modport sink (input valid, feedback_torque, accel_request, velocity, enable_in,
                output ready);
endinterface

// ----- design/tfc_command_if.sv -----
// Result channel carrying one current command per handshake.
// Depends on tfc_pkg.
interface tfc_command_if import tfc_pkg::*; ();
  logic  valid;
  logic  ready;
  word_t torque_request;
  word_t current_q;
  logic  enable_out;
  logic  torque_clamped;
  word_t accel_torque;
  word_t friction_torque;

  modport source (output valid, torque_request, current_q, enable_out, torque_clamped,
                  accel_torque, friction_torque, input ready);
  modport sink (input valid, torque_request, current_q, enable_out, torque_clamped,
                accel_torque, friction_torque, output ready);
endinterface

// ----- design/torque_feedforward_to_current_command_core.sv -----
// Torque feedforward with friction compensation and q-axis current command.
// Depends on tfc_pkg, tfc_demand_if and tfc_command_if.
//
// Usage: each request on the demand channel carries a feedback torque, an
// acceleration request, a measured velocity and an enable bit. The core adds
// acceleration feedforward and static plus viscous friction, clamps the torque
// to the torque limit, divides by the torque constant and clamps the result to
// the current limit. One result leaves on the command channel for each request.
// Both channels use a valid/ready handshake.
// A new request is accepted every cycle unless a result waits unaccepted; the
// rate is set by a fully pipelined datapath whose longest part is a 31-stage
// restoring divider, one quotient bit a stage. When the receiver stalls with a
// result waiting, the whole pipeline holds and demand.ready falls; nothing is
// dropped or repeated. Configuration registers sit on an APB-style port at byte
// address 4*index and may be written only while no request is in flight. Reset
// is synchronous and empties the pipeline and restores register defaults; no
// clearing pass.
module torque_feedforward_to_current_command_core import tfc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  tfc_demand_if.sink        demand,
  tfc_command_if.source     command
);

  typedef struct packed {
    logic [WORD_W-1:0] r;
    logic [QBITS-1:0]  dq;
    logic              ovf;
    logic              kzero;
    logic              neg;
    word_t             t_lim;
    logic              clamped;
    word_t             accel;
    word_t             fric;
    logic              en;
  } div_stage_t;

  cfg_t                 accel_gain;
  logic [WORD_W-1:0]    inertia;
  cfg_t                 static_friction;
  cfg_t                 viscous_friction;
  cfg_t                 torque_limit;
  cfg_t                 current_limit;
  cfg_t                 torque_constant;

  reg_idx_t             cfg_index;
  logic                 cfg_write;
  logic                 adv;

  logic [2*WORD_W-2:0]  s1_gi_prod;
  logic [2*WORD_W-2:0]  s1_visc_prod;
  word_t                s1_fb;
  word_t                s1_acc;
  logic                 s1_vel_pos;
  logic                 s1_vel_neg;
  logic                 s1_en;
  logic                 v1;

  logic [PROD_W-1:0]    gi_sum;
  logic [PROD_W-1:0]    visc_sum;
  logic [WORD_W-1:0]    s2_gi;
  word_t                s2_visc;
  word_t                s2_stat;
  word_t                s2_fb;
  word_t                s2_acc;
  logic                 s2_en;
  logic                 v2;

  logic [PROD_W-1:0]    s3_ap;
  logic                 s3_acc_neg;
  word_t                s3_fric;
  word_t                s3_fb;
  logic                 s3_en;
  logic                 v3;

  logic [PROD_W-1:0]    ap_sum;
  word_t                s4_accel;
  word_t                s4_fric;
  word_t                s4_fb;
  logic                 s4_en;
  logic                 v4;

  word_t                s5_sum;
  word_t                s5_accel;
  word_t                s5_fric;
  logic                 s5_en;
  logic                 v5;

  word_t                s6_raw;
  word_t                s6_accel;
  word_t                s6_fric;
  logic                 s6_en;
  logic                 v6;

  logic signed [WORD_W:0] lim_ext;
  logic signed [WORD_W:0] raw_ext;
  word_t                t_lim;
  word_t                s7_lim;
  logic                 s7_clamped;
  word_t                s7_accel;
  word_t                s7_fric;
  logic                 s7_en;
  logic                 v7;

  logic [WORD_W-1:0]    s8_mag;
  logic                 s8_neg;
  word_t                s8_lim;
  logic                 s8_clamped;
  word_t                s8_accel;
  word_t                s8_fric;
  logic                 s8_en;
  logic                 v8;

  div_stage_t           dstg [0:QBITS];
  logic                 dv   [0:QBITS];

  logic [QBITS-1:0]     q_mag;
  logic [QBITS-1:0]     i_mag;
  word_t                i_cmd;
  logic                 out_valid;

  assign pready    = 1'b1;
  assign cfg_index = paddr[ADDR_W-1:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      accel_gain       <= ACCEL_GAIN_RESET;
      inertia          <= '0;
      static_friction  <= '0;
      viscous_friction <= '0;
      torque_limit     <= '0;
      current_limit    <= '0;
      torque_constant  <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ACCEL_GAIN:       accel_gain       <= pwdata[CFG_W-1:0];
        REG_INERTIA:          inertia          <= pwdata[WORD_W-1:0];
        REG_STATIC_FRICTION:  static_friction  <= pwdata[CFG_W-1:0];
        REG_VISCOUS_FRICTION: viscous_friction <= pwdata[CFG_W-1:0];
        REG_TORQUE_LIMIT:     torque_limit     <= pwdata[CFG_W-1:0];
        REG_CURRENT_LIMIT:    current_limit    <= pwdata[CFG_W-1:0];
        REG_TORQUE_CONSTANT:  torque_constant  <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_index)
      REG_ACCEL_GAIN:       prdata = {1'b0, accel_gain};
      REG_INERTIA:          prdata = inertia;
      REG_STATIC_FRICTION:  prdata = {1'b0, static_friction};
      REG_VISCOUS_FRICTION: prdata = {1'b0, viscous_friction};
      REG_TORQUE_LIMIT:     prdata = {1'b0, torque_limit};
      REG_CURRENT_LIMIT:    prdata = {1'b0, current_limit};
      REG_TORQUE_CONSTANT:  prdata = {1'b0, torque_constant};
      default:              prdata = '0;
    endcase
  end

  // The pipeline moves as one; it holds only while a result waits unaccepted.
  assign adv          = !out_valid || command.ready;
  assign demand.ready = adv;

  // Stage 1: gain times inertia, viscous coefficient times speed.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= demand.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_gi_prod   <= (2*WORD_W-1)'(accel_gain) * (2*WORD_W-1)'(inertia);
      s1_visc_prod <= (2*WORD_W-1)'(viscous_friction) *
                      (2*WORD_W-1)'(mag_word(demand.velocity));
      s1_fb        <= demand.feedback_torque;
      s1_acc       <= demand.accel_request;
      s1_vel_pos   <= !demand.velocity[WORD_W-1] && (demand.velocity != '0);
      s1_vel_neg   <= demand.velocity[WORD_W-1];
      s1_en        <= demand.enable_in;
    end
  end

  // Stage 2: rounding of both products, static friction sign.
  assign gi_sum   = {1'b0, s1_gi_prod} + ROUND_INERTIA;
  assign visc_sum = {1'b0, s1_visc_prod} + ROUND_FRAC;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_gi   <= gi_sum[PROD_W-1:INERTIA_FRAC];
      s2_visc <= sat_mag(s1_vel_neg, visc_sum[PROD_W-1:FRAC_BITS]);
      if (s1_vel_pos) begin
        s2_stat <= word_t'({1'b0, static_friction});
      end else if (s1_vel_neg) begin
        s2_stat <= -word_t'({1'b0, static_friction});
      end else begin
        s2_stat <= '0;
      end
      s2_fb  <= s1_fb;
      s2_acc <= s1_acc;
      s2_en  <= s1_en;
    end
  end

  // Stage 3: acceleration product, friction sum.
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_ap      <= PROD_W'(s2_gi) * PROD_W'(mag_word(s2_acc));
      s3_acc_neg <= s2_acc[WORD_W-1];
      s3_fric    <= sat_add(s2_stat, s2_visc);
      s3_fb      <= s2_fb;
      s3_en      <= s2_en;
    end
  end

  // Stage 4: rounding and saturation of the acceleration term.
  assign ap_sum = s3_ap + ROUND_FRAC;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (adv) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_accel <= sat_mag(s3_acc_neg, ap_sum[PROD_W-1:FRAC_BITS]);
      s4_fric  <= s3_fric;
      s4_fb    <= s3_fb;
      s4_en    <= s3_en;
    end
  end

  // Stages 5 and 6: feedback plus acceleration, then plus friction.
  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else if (adv) begin
      v5 <= v4;
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_sum   <= sat_add(s4_fb, s4_accel);
      s5_accel <= s4_accel;
      s5_fric  <= s4_fric;
      s5_en    <= s4_en;
      s6_raw   <= sat_add(s5_sum, s5_fric);
      s6_accel <= s5_accel;
      s6_fric  <= s5_fric;
      s6_en    <= s5_en;
    end
  end

  // Stage 7: symmetric torque clamp.
  assign lim_ext = $signed({2'b00, torque_limit});
  assign raw_ext = {s6_raw[WORD_W-1], s6_raw};

  always_comb begin
    if (raw_ext > lim_ext) begin
      t_lim = lim_ext[WORD_W-1:0];
    end else if (raw_ext < -lim_ext) begin
      t_lim = word_t'(-lim_ext);
    end else begin
      t_lim = s6_raw;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
      v8 <= 1'b0;
    end else if (adv) begin
      v7 <= v6;
      v8 <= v7;
    end
  end

  // Stage 8: magnitude of the limited torque for the divider.
  always_ff @(posedge clk) begin
    if (adv) begin
      s7_lim     <= t_lim;
      s7_clamped <= (t_lim != s6_raw);
      s7_accel   <= s6_accel;
      s7_fric    <= s6_fric;
      s7_en      <= s6_en;
      s8_mag     <= mag_word(s7_lim);
      s8_neg     <= s7_lim[WORD_W-1];
      s8_lim     <= s7_lim;
      s8_clamped <= s7_clamped;
      s8_accel   <= s7_accel;
      s8_fric    <= s7_fric;
      s8_en      <= s7_en;
    end
  end

  // Divider entry: a quotient that needs more than QBITS bits is flagged as
  // overflow, so the remaining steps produce only the low QBITS bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else if (adv) begin
      dv[0] <= v8;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dstg[0].r       <= WORD_W'(s8_mag >> (QBITS - FRAC_BITS));
      dstg[0].dq      <= QBITS'(s8_mag << FRAC_BITS);
      dstg[0].ovf     <= (MAG_W'(s8_mag) >= (MAG_W'(torque_constant) << (QBITS - FRAC_BITS)));
      dstg[0].kzero   <= (torque_constant == '0);
      dstg[0].neg     <= s8_neg;
      dstg[0].t_lim   <= s8_lim;
      dstg[0].clamped <= s8_clamped;
      dstg[0].accel   <= s8_accel;
      dstg[0].fric    <= s8_fric;
      dstg[0].en      <= s8_en;
    end
  end

  for (genvar i = 0; i < QBITS; i++) begin : g_div
    logic [WORD_W-1:0] trial;
    logic              fits;
    div_stage_t        nxt;

    always_comb begin
      trial   = {dstg[i].r[WORD_W-2:0], dstg[i].dq[QBITS-1]};
      fits    = (trial >= {1'b0, torque_constant});
      nxt     = dstg[i];
      nxt.r   = fits ? (trial - {1'b0, torque_constant}) : trial;
      nxt.dq  = {dstg[i].dq[QBITS-2:0], fits};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[i+1] <= 1'b0;
      end else if (adv) begin
        dv[i+1] <= dv[i];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dstg[i+1] <= nxt;
      end
    end
  end

  // Output stage: current clamp and sign.
  assign q_mag = dstg[QBITS].dq;
  assign i_mag = (dstg[QBITS].ovf || (q_mag > current_limit)) ? current_limit : q_mag;

  always_comb begin
    if (dstg[QBITS].kzero) begin
      i_cmd = '0;
    end else if (dstg[QBITS].neg) begin
      i_cmd = -word_t'({1'b0, i_mag});
    end else begin
      i_cmd = word_t'({1'b0, i_mag});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= dv[QBITS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      command.torque_request  <= dstg[QBITS].t_lim;
      command.current_q       <= i_cmd;
      command.enable_out      <= dstg[QBITS].en;
      command.torque_clamped  <= dstg[QBITS].clamped;
      command.accel_torque    <= dstg[QBITS].accel;
      command.friction_torque <= dstg[QBITS].fric;
    end
  end

  assign command.valid = out_valid;

  a_torque_in_limit: assert property (@(posedge clk) disable iff (rst)
    command.valid |-> ($signed({command.torque_request[WORD_W-1], command.torque_request})
                       <= $signed({2'b00, torque_limit})) &&
                      ($signed({command.torque_request[WORD_W-1], command.torque_request})
                       >= -$signed({2'b00, torque_limit})))
    else $error("torque request outside the torque limit");

  a_current_in_limit: assert property (@(posedge clk) disable iff (rst)
    command.valid |-> (mag_word(command.current_q) <= {1'b0, current_limit}))
    else $error("current command outside the current limit");

  a_zero_constant: assert property (@(posedge clk) disable iff (rst)
    (command.valid && (torque_constant == '0)) |-> (command.current_q == '0))
    else $error("nonzero current with a zero torque constant");

  a_current_sign: assert property (@(posedge clk) disable iff (rst)
    (command.valid && (command.current_q != '0)) |->
      (command.current_q[WORD_W-1] == command.torque_request[WORD_W-1]))
    else $error("current command sign differs from torque sign");

endmodule
